// ===== hdl/pdl_pkg.sv =====
`default_nettype none
package pdl_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int WORD_WIDTH_DEF = 32;
    localparam int NUM_AXES       = 3;
    localparam int NORM_W         = 31;
    localparam int SUM_W          = 64;
    localparam int ROOT_W         = 32;
    localparam int QUO_W          = 32;
    localparam int SHIFT_W        = 7;
    localparam int REG_IDX_W      = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_KP_X,
        REG_KP_Y,
        REG_KP_Z,
        REG_KV_X,
        REG_KV_Y,
        REG_KV_Z,
        REG_ACCEL_LIMIT
    } reg_idx_t;

    typedef struct packed {
        logic                limited;
        logic [NUM_AXES-1:0] neg;
        logic [SHIFT_W-1:0]  shift;
        logic [NORM_W-1:0]   lim_norm;
    } ctl_t;

    // 9.81 rounded to nearest in Q.frac
    function automatic logic [63:0] grav_q(input int frac);
        return ((64'd981 << frac) + 64'd50) / 64'd100;
    endfunction

    // clamp a 64-bit two's complement value to w signed bits
    function automatic logic [63:0] sat_word(input logic [63:0] t, input int w);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        logic signed [63:0] ts;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        ts = signed'(t);
        if (ts > hi)
        begin
            return hi;
        end
        else if (ts < lo)
        begin
            return lo;
        end
        return ts;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/pdl_front.sv =====
`default_nettype none
module pdl_front
    import pdl_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [NUM_AXES-1:0][WORD_WIDTH-1:0]  kp,
    input  wire logic [NUM_AXES-1:0][WORD_WIDTH-1:0]  kv,
    input  wire logic [WORD_WIDTH-1:0]                accel_limit,
    input  wire logic [NUM_AXES-1:0][WORD_WIDTH-1:0]  pos_err,
    input  wire logic [NUM_AXES-1:0][WORD_WIDTH-1:0]  vel_err,
    input  wire logic [NUM_AXES-1:0][WORD_WIDTH-1:0]  ff_accel,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [NUM_AXES-1:0][NORM_W-1:0]           out_norm,
    output logic [SUM_W-1:0]                          out_sum,
    output ctl_t                                      out_ctl,
    output logic [NUM_AXES-1:0][WORD_WIDTH-1:0]       out_pay
);

    localparam int W   = WORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int PW  = 2 * W + 1;
    localparam int AW  = 2 * W + 2;
    localparam int MW  = AW - F;
    localparam int BLW = $clog2(((MW > W) ? MW : W) + 1);
    localparam int EW  = MW + 64;
    localparam int LEW = W + 64;
    localparam int SQW = 2 * NORM_W;
    localparam int NUM_STAGES = 6;
    localparam logic [63:0] GRAV = grav_q(F);
    localparam logic [63:0] CAP64 = 64'h4000_0000_0000_0000;
    localparam logic [EW-1:0] CAP = EW'(CAP64);

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES:0]   en;

    assign en[NUM_STAGES] = out_ready;
    for (genvar k = 0; k < NUM_STAGES; k++)
    begin : g_en
        assign en[k] = !vld_reg[k] || en[k+1];
    end
    assign in_ready  = en[0];
    assign out_valid = vld_reg[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 1: gain products
    logic signed [PW-1:0]             pp_reg [NUM_AXES];
    logic signed [PW-1:0]             pv_reg [NUM_AXES];
    logic [NUM_AXES-1:0][W-1:0]       ff1_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                pp_reg[i] <= $signed({1'b0, kp[i]}) * $signed(pos_err[i]);
                pv_reg[i] <= $signed({1'b0, kv[i]}) * $signed(vel_err[i]);
            end
            ff1_reg <= ff_accel;
        end
    end

    // stage 2: sum, drop fraction, magnitude
    logic signed [AW-1:0]             acc2 [NUM_AXES];
    logic signed [AW-1:0]             sh2 [NUM_AXES];
    logic [AW-1:0]                    abs2 [NUM_AXES];
    logic [MW-1:0]                    mag2_reg [NUM_AXES];
    logic [NUM_AXES-1:0]              neg2_reg;
    logic [NUM_AXES-1:0][W-1:0]       ff2_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            acc2[i] = AW'(pp_reg[i]) + AW'(pv_reg[i]);
            sh2[i]  = acc2[i] >>> F;
            abs2[i] = sh2[i][AW-1] ? AW'(-sh2[i]) : AW'(sh2[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                mag2_reg[i] <= abs2[i][MW-1:0];
                neg2_reg[i] <= sh2[i][AW-1];
            end
            ff2_reg <= ff1_reg;
        end
    end

    // stage 3: common normalizing shift
    logic [BLW-1:0]                   blm3 [NUM_AXES];
    logic [BLW-1:0]                   bll3;
    logic [BLW-1:0]                   blmax3;
    logic [SHIFT_W-1:0]               s3_next;
    logic [SHIFT_W-1:0]               s3_reg;
    logic [MW-1:0]                    mag3_reg [NUM_AXES];
    logic [NUM_AXES-1:0]              neg3_reg;
    logic [NUM_AXES-1:0][W-1:0]       ff3_reg;

    always_comb
    begin
        bll3 = '0;
        for (int b = 0; b < W; b++)
        begin
            if (accel_limit[b])
            begin
                bll3 = BLW'(b + 1);
            end
        end
        blmax3 = bll3;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            blm3[i] = '0;
            for (int b = 0; b < MW; b++)
            begin
                if (mag2_reg[i][b])
                begin
                    blm3[i] = BLW'(b + 1);
                end
            end
            if (blm3[i] > blmax3)
            begin
                blmax3 = blm3[i];
            end
        end
        s3_next = (blmax3 > BLW'(NORM_W)) ? SHIFT_W'(blmax3 - BLW'(NORM_W)) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_reg   <= s3_next;
            mag3_reg <= mag2_reg;
            neg3_reg <= neg2_reg;
            ff3_reg  <= ff2_reg;
        end
    end

    // stage 4: normalize, unlimited result
    logic [EW-1:0]                    ext4 [NUM_AXES];
    logic [EW-1:0]                    sh4 [NUM_AXES];
    logic [LEW-1:0]                   lsh4;
    logic [63:0]                      a4 [NUM_AXES];
    logic [63:0]                      fbv4 [NUM_AXES];
    logic [63:0]                      t4 [NUM_AXES];
    logic [63:0]                      sat4 [NUM_AXES];
    logic [NUM_AXES-1:0][NORM_W-1:0]  m4_reg;
    logic [NORM_W-1:0]                lp4_reg;
    logic [SHIFT_W-1:0]               s4_reg;
    logic [NUM_AXES-1:0]              neg4_reg;
    logic [NUM_AXES-1:0][W-1:0]       nl4_reg;
    logic [NUM_AXES-1:0][W-1:0]       ff4_reg;

    always_comb
    begin
        lsh4 = LEW'(accel_limit) >> s3_reg;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            ext4[i] = EW'(mag3_reg[i]);
            sh4[i]  = ext4[i] >> s3_reg;
            a4[i]   = (ext4[i] > CAP) ? CAP64 : ext4[i][63:0];
            fbv4[i] = neg3_reg[i] ? -a4[i] : a4[i];
            t4[i]   = fbv4[i] + 64'(signed'(ff3_reg[i]))
                    + ((i == NUM_AXES - 1) ? GRAV : 64'd0);
            sat4[i] = sat_word(t4[i], W);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                m4_reg[i]  <= sh4[i][NORM_W-1:0];
                nl4_reg[i] <= sat4[i][W-1:0];
            end
            lp4_reg  <= lsh4[NORM_W-1:0];
            s4_reg   <= s3_reg;
            neg4_reg <= neg3_reg;
            ff4_reg  <= ff3_reg;
        end
    end

    // stage 5: squares
    logic [SQW-1:0]                   sq5_reg [NUM_AXES];
    logic [SQW-1:0]                   lp25_reg;
    logic [NUM_AXES-1:0][NORM_W-1:0]  m5_reg;
    logic [NORM_W-1:0]                lp5_reg;
    logic [SHIFT_W-1:0]               s5_reg;
    logic [NUM_AXES-1:0]              neg5_reg;
    logic [NUM_AXES-1:0][W-1:0]       nl5_reg;
    logic [NUM_AXES-1:0][W-1:0]       ff5_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                sq5_reg[i] <= SQW'(m4_reg[i]) * SQW'(m4_reg[i]);
            end
            lp25_reg <= SQW'(lp4_reg) * SQW'(lp4_reg);
            m5_reg   <= m4_reg;
            lp5_reg  <= lp4_reg;
            s5_reg   <= s4_reg;
            neg5_reg <= neg4_reg;
            nl5_reg  <= nl4_reg;
            ff5_reg  <= ff4_reg;
        end
    end

    // stage 6: sum of squares, limit compare
    logic [SUM_W-1:0]                 sum6;
    logic                             lim6;
    logic [NUM_AXES-1:0][NORM_W-1:0]  norm_reg;
    logic [SUM_W-1:0]                 sum_reg;
    ctl_t                             ctl_reg;
    logic [NUM_AXES-1:0][W-1:0]       pay_reg;

    always_comb
    begin
        sum6 = SUM_W'(sq5_reg[0]) + SUM_W'(sq5_reg[1]) + SUM_W'(sq5_reg[2]);
        lim6 = sum6 > SUM_W'(lp25_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            norm_reg         <= m5_reg;
            sum_reg          <= sum6;
            ctl_reg.limited  <= lim6;
            ctl_reg.neg      <= neg5_reg;
            ctl_reg.shift    <= s5_reg;
            ctl_reg.lim_norm <= lp5_reg;
            pay_reg          <= lim6 ? ff5_reg : nl5_reg;
        end
    end

    assign out_norm = norm_reg;
    assign out_sum  = sum_reg;
    assign out_ctl  = ctl_reg;
    assign out_pay  = pay_reg;

endmodule
`default_nettype wire

// ===== hdl/pdl_sqrt.sv =====
`default_nettype none
module pdl_sqrt
    import pdl_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [SUM_W-1:0]  in_radicand,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [ROOT_W-1:0]      out_root,
    output logic [SIDE_W-1:0]      out_side
);

    localparam int NUM_STAGES = ROOT_W;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES:0]   en;
    logic [SUM_W-1:0]      v_reg [NUM_STAGES];
    logic [SUM_W-1:0]      res_reg [NUM_STAGES];
    logic [SIDE_W-1:0]     side_reg [NUM_STAGES];

    assign en[NUM_STAGES] = out_ready;
    assign in_ready  = en[0];
    assign out_valid = vld_reg[NUM_STAGES-1];
    assign out_root  = res_reg[NUM_STAGES-1][ROOT_W-1:0];
    assign out_side  = side_reg[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // one result bit per stage
    for (genvar k = 0; k < NUM_STAGES; k++)
    begin : g_step
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);

        logic [SUM_W-1:0]  v_in;
        logic [SUM_W-1:0]  res_in;
        logic [SIDE_W-1:0] side_in;
        logic [SUM_W:0]    trial;
        logic [SUM_W-1:0]  v_next;
        logic [SUM_W-1:0]  res_next;

        assign en[k] = !vld_reg[k] || en[k+1];

        if (k == 0)
        begin : g_first
            assign v_in    = in_radicand;
            assign res_in  = '0;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[k-1];
            assign res_in  = res_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb
        begin
            trial = {1'b0, res_in} + {1'b0, BIT};
            if ({1'b0, v_in} >= trial)
            begin
                v_next   = v_in - trial[SUM_W-1:0];
                res_next = (res_in >> 1) + BIT;
            end
            else
            begin
                v_next   = v_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                v_reg[k]    <= v_next;
                res_reg[k]  <= res_next;
                side_reg[k] <= side_in;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/pdl_div.sv =====
`default_nettype none
module pdl_div
    import pdl_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [NUM_AXES-1:0][NORM_W-1:0]  in_dividend,
    input  wire logic [ROOT_W-1:0]                in_divisor,
    input  wire logic [SIDE_W-1:0]                in_side,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [NUM_AXES-1:0][QUO_W-1:0]        out_quot,
    output logic [SIDE_W-1:0]                     out_side
);

    // quotient of (dividend << NORM_W) / divisor, one bit per stage
    localparam int NUM_STAGES = QUO_W;

    logic [NUM_STAGES-1:0]                vld_reg;
    logic [NUM_STAGES:0]                  en;
    logic [NUM_AXES-1:0][ROOT_W-1:0]      rem_reg [NUM_STAGES];
    logic [NUM_AXES-1:0][QUO_W-1:0]       q_reg [NUM_STAGES];
    logic [ROOT_W-1:0]                    n_reg [NUM_STAGES];
    logic [SIDE_W-1:0]                    side_reg [NUM_STAGES];

    assign en[NUM_STAGES] = out_ready;
    assign in_ready  = en[0];
    assign out_valid = vld_reg[NUM_STAGES-1];
    assign out_quot  = q_reg[NUM_STAGES-1];
    assign out_side  = side_reg[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    for (genvar k = 0; k < NUM_STAGES; k++)
    begin : g_step
        logic [NUM_AXES-1:0][ROOT_W:0]   r_in;
        logic [NUM_AXES-1:0][QUO_W-1:0]  q_in;
        logic [ROOT_W-1:0]               n_in;
        logic [SIDE_W-1:0]               side_in;
        logic [ROOT_W:0]                 diff [NUM_AXES];
        logic [NUM_AXES-1:0]             ge;
        logic [NUM_AXES-1:0][ROOT_W-1:0] rem_next;
        logic [NUM_AXES-1:0][QUO_W-1:0]  q_next;

        assign en[k] = !vld_reg[k] || en[k+1];

        if (k == 0)
        begin : g_first
            for (genvar i = 0; i < NUM_AXES; i++)
            begin : g_lane
                assign r_in[i] = (ROOT_W + 1)'(in_dividend[i]);
            end
            assign q_in    = '0;
            assign n_in    = in_divisor;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            for (genvar i = 0; i < NUM_AXES; i++)
            begin : g_lane
                assign r_in[i] = {rem_reg[k-1][i], 1'b0};
            end
            assign q_in    = q_reg[k-1];
            assign n_in    = n_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                diff[i]     = r_in[i] - {1'b0, n_in};
                ge[i]       = r_in[i] >= {1'b0, n_in};
                rem_next[i] = ge[i] ? diff[i][ROOT_W-1:0] : r_in[i][ROOT_W-1:0];
                q_next[i]   = {q_in[i][QUO_W-2:0], ge[i]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k]  <= rem_next;
                q_reg[k]    <= q_next;
                n_reg[k]    <= n_in;
                side_reg[k] <= side_in;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/pdl_back.sv =====
`default_nettype none
module pdl_back
    import pdl_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [NUM_AXES-1:0][QUO_W-1:0]       in_quot,
    input  wire ctl_t                                 in_ctl,
    input  wire logic [NUM_AXES-1:0][WORD_WIDTH-1:0]  in_pay,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [NUM_AXES-1:0][WORD_WIDTH-1:0]       out_accel,
    output logic                                      out_limited
);

    localparam int W  = WORD_WIDTH;
    localparam int PW = NORM_W + QUO_W;
    localparam int NUM_STAGES = 3;
    localparam logic [63:0] GRAV = grav_q(FRAC_BITS);
    localparam logic [SHIFT_W-1:0] NORM_SH = SHIFT_W'(NORM_W);

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES:0]   en;

    assign en[NUM_STAGES] = out_ready;
    for (genvar k = 0; k < NUM_STAGES; k++)
    begin : g_en
        assign en[k] = !vld_reg[k] || en[k+1];
    end
    assign in_ready  = en[0];
    assign out_valid = vld_reg[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 1: limit times unit vector
    logic [PW-1:0]                p1_reg [NUM_AXES];
    ctl_t                         ctl1_reg;
    logic [NUM_AXES-1:0][W-1:0]   pay1_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                p1_reg[i] <= PW'(in_ctl.lim_norm) * PW'(in_quot[i]);
            end
            ctl1_reg <= in_ctl;
            pay1_reg <= in_pay;
        end
    end

    // stage 2: undo normalization, apply sign
    logic [63:0]                  a2 [NUM_AXES];
    logic [63:0]                  fbv2_reg [NUM_AXES];
    ctl_t                         ctl2_reg;
    logic [NUM_AXES-1:0][W-1:0]   pay2_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if (ctl1_reg.shift >= NORM_SH)
            begin
                a2[i] = 64'(p1_reg[i]) << (ctl1_reg.shift - NORM_SH);
            end
            else
            begin
                a2[i] = 64'(p1_reg[i]) >> (NORM_SH - ctl1_reg.shift);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                fbv2_reg[i] <= ctl1_reg.neg[i] ? -a2[i] : a2[i];
            end
            ctl2_reg <= ctl1_reg;
            pay2_reg <= pay1_reg;
        end
    end

    // stage 3: feedforward, gravity, saturate; pass the payload through when not limited
    logic [63:0]                  t3 [NUM_AXES];
    logic [63:0]                  sat3 [NUM_AXES];
    logic [NUM_AXES-1:0][W-1:0]   accel_reg;
    logic                         limited_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            t3[i]   = fbv2_reg[i] + 64'(signed'(pay2_reg[i]))
                    + ((i == NUM_AXES - 1) ? GRAV : 64'd0);
            sat3[i] = sat_word(t3[i], W);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                accel_reg[i] <= ctl2_reg.limited ? sat3[i][W-1:0] : pay2_reg[i];
            end
            limited_reg <= ctl2_reg.limited;
        end
    end

    assign out_accel   = accel_reg;
    assign out_limited = limited_reg;

endmodule
`default_nettype wire

// ===== hdl/pd_accel_command_with_norm_limit_top.sv =====
// Channel  | Handshake            | Beat contents
// ---------+----------------------+------------------------------------------------
// cfg      | cfg_we               | cfg_index, cfg_data (gains, accel limit)
// in       | in_valid / in_ready  | position_error_*, velocity_error_*, feedforward_*
// out      | out_valid / out_ready| desired_accel_*, feedback_limited
//
// One beat per cycle while out_ready is high; 6 front stages, 32 square-root stages,
// 32 divider stages (one result bit per stage each), 3 output stages.
// Reset clears all stage valid bits and loads the register defaults.
// Each full stage holds while the one after it cannot advance; in_ready drops only when
// every stage holds a beat.
`default_nettype none
module pd_accel_command_with_norm_limit_top
    import pdl_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [REG_IDX_W-1:0]    cfg_index,
    input  wire logic [WORD_WIDTH-1:0]   cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [WORD_WIDTH-1:0]   position_error_x,
    input  wire logic [WORD_WIDTH-1:0]   position_error_y,
    input  wire logic [WORD_WIDTH-1:0]   position_error_z,
    input  wire logic [WORD_WIDTH-1:0]   velocity_error_x,
    input  wire logic [WORD_WIDTH-1:0]   velocity_error_y,
    input  wire logic [WORD_WIDTH-1:0]   velocity_error_z,
    input  wire logic [WORD_WIDTH-1:0]   feedforward_accel_x,
    input  wire logic [WORD_WIDTH-1:0]   feedforward_accel_y,
    input  wire logic [WORD_WIDTH-1:0]   feedforward_accel_z,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [WORD_WIDTH-1:0]        desired_accel_x,
    output logic [WORD_WIDTH-1:0]        desired_accel_y,
    output logic [WORD_WIDTH-1:0]        desired_accel_z,
    output logic                         feedback_limited
);

    localparam int W = WORD_WIDTH;
    localparam logic [W-1:0] GAIN_RST  = W'(1) << FRAC_BITS;
    localparam logic [W-1:0] LIMIT_RST = W'(5) << FRAC_BITS;
    localparam int CTL_W     = $bits(ctl_t);
    localparam int PAY_W     = NUM_AXES * W;
    localparam int SQ_SIDE_W = NUM_AXES * NORM_W + CTL_W + PAY_W;
    localparam int DV_SIDE_W = CTL_W + PAY_W;

    logic [NUM_AXES-1:0][W-1:0] kp_reg;
    logic [NUM_AXES-1:0][W-1:0] kv_reg;
    logic [W-1:0]               accel_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg          <= {NUM_AXES{GAIN_RST}};
            kv_reg          <= {NUM_AXES{GAIN_RST}};
            accel_limit_reg <= LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_KP_X:        kp_reg[0] <= cfg_data;
                REG_KP_Y:        kp_reg[1] <= cfg_data;
                REG_KP_Z:        kp_reg[2] <= cfg_data;
                REG_KV_X:        kv_reg[0] <= cfg_data;
                REG_KV_Y:        kv_reg[1] <= cfg_data;
                REG_KV_Z:        kv_reg[2] <= cfg_data;
                REG_ACCEL_LIMIT: accel_limit_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    logic                             fr_valid;
    logic                             fr_ready;
    logic [NUM_AXES-1:0][NORM_W-1:0]  fr_norm;
    logic [SUM_W-1:0]                 fr_sum;
    ctl_t                             fr_ctl;
    logic [NUM_AXES-1:0][W-1:0]       fr_pay;

    pdl_front #(
        .FRAC_BITS  (FRAC_BITS),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kp          (kp_reg),
        .kv          (kv_reg),
        .accel_limit (accel_limit_reg),
        .pos_err     ({position_error_z, position_error_y, position_error_x}),
        .vel_err     ({velocity_error_z, velocity_error_y, velocity_error_x}),
        .ff_accel    ({feedforward_accel_z, feedforward_accel_y, feedforward_accel_x}),
        .out_valid   (fr_valid),
        .out_ready   (fr_ready),
        .out_norm    (fr_norm),
        .out_sum     (fr_sum),
        .out_ctl     (fr_ctl),
        .out_pay     (fr_pay)
    );

    logic                             sq_valid;
    logic                             sq_ready;
    logic [ROOT_W-1:0]                sq_root;
    logic [SQ_SIDE_W-1:0]             sq_side;
    logic [NUM_AXES-1:0][NORM_W-1:0]  sq_norm;
    ctl_t                             sq_ctl;
    logic [NUM_AXES-1:0][W-1:0]       sq_pay;

    pdl_sqrt #(
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (fr_valid),
        .in_ready    (fr_ready),
        .in_radicand (fr_sum),
        .in_side     ({fr_norm, fr_ctl, fr_pay}),
        .out_valid   (sq_valid),
        .out_ready   (sq_ready),
        .out_root    (sq_root),
        .out_side    (sq_side)
    );

    assign {sq_norm, sq_ctl, sq_pay} = sq_side;

    logic                             dv_valid;
    logic                             dv_ready;
    logic [NUM_AXES-1:0][QUO_W-1:0]   dv_quot;
    logic [DV_SIDE_W-1:0]             dv_side;
    ctl_t                             dv_ctl;
    logic [NUM_AXES-1:0][W-1:0]       dv_pay;

    pdl_div #(
        .SIDE_W (DV_SIDE_W)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (sq_valid),
        .in_ready    (sq_ready),
        .in_dividend (sq_norm),
        .in_divisor  (sq_root),
        .in_side     ({sq_ctl, sq_pay}),
        .out_valid   (dv_valid),
        .out_ready   (dv_ready),
        .out_quot    (dv_quot),
        .out_side    (dv_side)
    );

    assign {dv_ctl, dv_pay} = dv_side;

    logic [NUM_AXES-1:0][W-1:0] accel;

    pdl_back #(
        .FRAC_BITS  (FRAC_BITS),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (dv_valid),
        .in_ready    (dv_ready),
        .in_quot     (dv_quot),
        .in_ctl      (dv_ctl),
        .in_pay      (dv_pay),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_accel   (accel),
        .out_limited (feedback_limited)
    );

    assign desired_accel_x = accel[0];
    assign desired_accel_y = accel[1];
    assign desired_accel_z = accel[2];

endmodule
`default_nettype wire

// ===== sim/pdl_checker.sv =====
`default_nettype none
module pdl_checker
    import pdl_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 in_valid,
    input  wire logic                 in_ready,
    input  wire logic [8:0][31:0]     in_beat,
    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  wire logic [31:0]          desired_accel_x,
    input  wire logic [31:0]          desired_accel_y,
    input  wire logic [31:0]          desired_accel_z,
    input  wire logic                 feedback_limited,
    output int                        fail_count,
    output int                        pending,
    output int                        limited_seen
);

    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic        lim;
    } accel_t;

    localparam logic [63:0] GRAVITY_Q16 = ((64'd981 << 16) + 64'd50) / 64'd100;

    logic [31:0] gain_regs [7];
    accel_t      accel_q [$];

    function automatic int bit_length(input logic [127:0] v);
        int n;
        n = 0;
        for (int k = 0; k < 128; k++)
        begin
            if (v[k])
            begin
                n = k + 1;
            end
        end
        return n;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] cand;
        res = 0;
        for (int b = 31; b >= 0; b--)
        begin
            cand = res | (64'd1 << b);
            if (cand * cand <= v)
            begin
                res = cand;
            end
        end
        return res;
    endfunction

    function automatic accel_t compute_accel(input logic [8:0][31:0] it);
        logic signed [127:0] acc;
        logic [127:0]        mag [3];
        logic                neg [3];
        logic [63:0]         m [3];
        logic [63:0]         lp;
        logic [63:0]         sumsq;
        logic [63:0]         n;
        logic [63:0]         q;
        logic [63:0]         p;
        logic [63:0]         a;
        logic signed [63:0]  t;
        logic [31:0]         lim;
        logic [31:0]         sat [3];
        logic                limited;
        int                  bl;
        int                  s;
        accel_t              r;
        lim = gain_regs[REG_ACCEL_LIMIT];
        bl = bit_length({96'b0, lim});
        for (int i = 0; i < 3; i++)
        begin
            acc = $signed({96'b0, gain_regs[i]}) * $signed({{96{it[i][31]}}, it[i]})
                + $signed({96'b0, gain_regs[3 + i]})
                  * $signed({{96{it[3 + i][31]}}, it[3 + i]});
            acc = acc >>> 16;
            neg[i] = acc[127];
            mag[i] = neg[i] ? -acc : acc;
            if (bit_length(mag[i]) > bl)
            begin
                bl = bit_length(mag[i]);
            end
        end
        s = bl > 31 ? bl - 31 : 0;
        lp = {32'b0, lim} >> s;
        sumsq = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = 64'(mag[i] >> s);
            sumsq += m[i] * m[i];
        end
        limited = sumsq > lp * lp;
        n = floor_sqrt(sumsq);
        for (int i = 0; i < 3; i++)
        begin
            if (limited)
            begin
                q = (m[i] << 31) / n;
                p = lp * q;
                a = s >= 31 ? p << (s - 31) : p >> (31 - s);
            end
            else
            begin
                a = (mag[i][127:64] != 0 || mag[i][63:0] > (64'd1 << 62))
                    ? (64'd1 << 62) : mag[i][63:0];
            end
            t = neg[i] ? -$signed(a) : $signed(a);
            t = t + $signed({{32{it[6 + i][31]}}, it[6 + i]});
            if (i == 2)
            begin
                t = t + $signed(GRAVITY_Q16);
            end
            if (t > 64'sd2147483647)
            begin
                t = 64'sd2147483647;
            end
            if (t < -64'sd2147483648)
            begin
                t = -64'sd2147483648;
            end
            sat[i] = t[31:0];
        end
        r.ax = sat[0];
        r.ay = sat[1];
        r.az = sat[2];
        r.lim = limited;
        return r;
    endfunction

    assign pending = accel_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        accel_t exp_r;
        accel_t got;
        if (!rst_n)
        begin
            gain_regs[0] <= 32'd65536;
            gain_regs[1] <= 32'd65536;
            gain_regs[2] <= 32'd65536;
            gain_regs[3] <= 32'd65536;
            gain_regs[4] <= 32'd65536;
            gain_regs[5] <= 32'd65536;
            gain_regs[6] <= 32'd327680;
            fail_count <= 0;
            limited_seen <= 0;
            accel_q.delete();
        end
        else
        begin
            if (cfg_we && cfg_index <= REG_ACCEL_LIMIT)
            begin
                gain_regs[cfg_index] <= cfg_data;
            end
            if (in_valid && in_ready)
            begin
                accel_q.push_back(compute_accel(in_beat));
            end
            if (out_valid && out_ready)
            begin
                got = {desired_accel_x, desired_accel_y, desired_accel_z, feedback_limited};
                if (accel_q.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("unexpected beat at %0t: %h", $realtime, got);
                    end
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = accel_q.pop_front();
                    if (got.lim)
                    begin
                        limited_seen <= limited_seen + 1;
                    end
                    if (got !== exp_r)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("mismatch at %0t: x exp %h got %h, y exp %h got %h, %s",
                                     $realtime, exp_r.ax, got.ax, exp_r.ay, got.ay,
                                     $sformatf("z exp %h got %h, limited exp %b got %b",
                                               exp_r.az, got.az, exp_r.lim, got.lim));
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== sim/tb_pd_accel_command_with_norm_limit_top.sv =====
`default_nettype none
module tb_pd_accel_command_with_norm_limit_top;
    import pdl_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 90;
    localparam logic [REG_IDX_W-1:0] UNMAPPED_INDEX = 3'd7;

    logic                 clk = 0;
    logic                 rst_n = 0;
    logic                 cfg_we = 0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    logic                 in_valid = 0;
    logic                 in_ready;
    logic [8:0][31:0]     beat = '0;
    logic                 out_valid;
    logic                 out_ready = 0;
    logic [31:0]          desired_accel_x;
    logic [31:0]          desired_accel_y;
    logic [31:0]          desired_accel_z;
    logic                 feedback_limited;
    int                   fail_count;
    int                   pending;
    int                   limited_seen;
    int                   cycles = 0;
    int                   sent = 0;
    int                   settings = 0;
    int                   stall_mode = 0;

    always #10 clk = ~clk;

    pd_accel_command_with_norm_limit_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .position_error_x(beat[0]), .position_error_y(beat[1]), .position_error_z(beat[2]),
        .velocity_error_x(beat[3]), .velocity_error_y(beat[4]), .velocity_error_z(beat[5]),
        .feedforward_accel_x(beat[6]), .feedforward_accel_y(beat[7]),
        .feedforward_accel_z(beat[8]),
        .out_valid(out_valid), .out_ready(out_ready),
        .desired_accel_x(desired_accel_x), .desired_accel_y(desired_accel_y),
        .desired_accel_z(desired_accel_z), .feedback_limited(feedback_limited)
    );

    pdl_checker chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_beat(beat),
        .out_valid(out_valid), .out_ready(out_ready),
        .desired_accel_x(desired_accel_x), .desired_accel_y(desired_accel_y),
        .desired_accel_z(desired_accel_z), .feedback_limited(feedback_limited),
        .fail_count(fail_count), .pending(pending), .limited_seen(limited_seen)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("pd_accel_command_with_norm_limit_top test failed");
            $finish;
        end
    end

    // receiver stall pattern: mode is redrawn at random from four patterns
    always @(negedge clk)
    begin
        if (cycles % 64 == 0)
        begin
            stall_mode = $urandom_range(0, 3);
        end
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ((cycles / 5) % 2 == 0);
        endcase
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            3, 4: return $urandom_range(0, 20'hfffff);
            5, 6: return -$urandom_range(0, 20'hfffff);
            default: return $urandom_range(0, 24'hffffff) - 32'h00800000;
        endcase
    endfunction

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'hffffffff;
            2: return 32'd0;
            default: return $urandom_range(0, 32'h00080000);
        endcase
    endfunction

    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_all(input logic [31:0] pg, input logic [31:0] vg,
                           input logic [31:0] lim);
        cfg_write(REG_KP_X, pg);
        cfg_write(REG_KP_Y, pg);
        cfg_write(REG_KP_Z, pg);
        cfg_write(REG_KV_X, vg);
        cfg_write(REG_KV_Y, vg);
        cfg_write(REG_KV_Z, vg);
        cfg_write(REG_ACCEL_LIMIT, lim);
        settings++;
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_beat(input logic [8:0][31:0] b);
        beat = b;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        sent++;
    endtask

    task automatic send_random(input int count);
        logic [8:0][31:0] b;
        int burst;
        burst = 0;
        for (int k = 0; k < count; k++)
        begin
            if (burst == 0)
            begin
                in_valid = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
                burst = $urandom_range(1, 30);
            end
            for (int j = 0; j < 9; j++)
            begin
                b[j] = rand_word();
            end
            send_beat(b);
            burst--;
        end
        in_valid = 1'b0;
    endtask

    initial
    begin
        logic [8:0][31:0] d;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed beats at reset gains
        d = '0;
        send_beat(d);
        d[0] = 32'h00050000;
        send_beat(d);
        d[0] = 32'h00050001;
        send_beat(d);
        d = '0;
        d[3] = 32'hfffb0000;
        d[4] = 32'h00010000;
        send_beat(d);
        for (int j = 0; j < 9; j++)
        begin
            d[j] = 32'h7fffffff;
        end
        send_beat(d);
        for (int j = 0; j < 9; j++)
        begin
            d[j] = 32'h80000000;
        end
        send_beat(d);
        d = '0;
        d[6] = 32'h7fffffff;
        d[7] = 32'h80000000;
        d[8] = 32'h7fffffff;
        send_beat(d);
        d[8] = 32'h80000000;
        d[1] = 32'hffff0000;
        send_beat(d);
        d = '0;
        d[0] = 32'hffffffff;
        d[5] = 32'h00000001;
        send_beat(d);
        drain();

        // zero limit, max gains
        set_all(32'hffffffff, 32'hffffffff, 32'd0);
        d = '0;
        send_beat(d);
        d[2] = 32'h00000001;
        send_beat(d);
        for (int j = 0; j < 9; j++)
        begin
            d[j] = 32'h80000000;
        end
        send_beat(d);
        drain();

        // max limit; unknown index must be ignored
        set_all(32'hffffffff, 32'd0, 32'hffffffff);
        cfg_write(UNMAPPED_INDEX, 32'd0);
        for (int j = 0; j < 9; j++)
        begin
            d[j] = 32'h7fffffff;
        end
        send_beat(d);
        d[0] = 32'h80000000;
        send_beat(d);
        send_random(20);
        drain();

        set_all(32'd0, 32'd0, 32'd65536);
        send_random(10);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            cfg_write(REG_KP_X, rand_gain());
            cfg_write(REG_KP_Y, rand_gain());
            cfg_write(REG_KP_Z, rand_gain());
            cfg_write(REG_KV_X, rand_gain());
            cfg_write(REG_KV_Y, rand_gain());
            cfg_write(REG_KV_Z, rand_gain());
            cfg_write(REG_ACCEL_LIMIT, ph == 0 ? 32'd327680 : rand_gain());
            settings++;
            send_random(40);
            drain();
            send_random(40);
            drain();
        end

        $display("sent %0d beats over %0d gain/limit settings, %0d results limited",
                 sent, settings, limited_seen);
        if (fail_count == 0)
        begin
            $display("pd_accel_command_with_norm_limit_top test passed");
        end
        else
        begin
            $display("pd_accel_command_with_norm_limit_top test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
